/* design/rrtt_pkg.sv */
// Shared types and constants for the round-robin task table.
package rrtt_pkg;

	localparam int NUM_SLOTS_DEF = 64;
	localparam int MODE_W        = 2;
	localparam int INDEX_W       = 6;
	localparam int WORD_W        = 32;
	localparam int STATUS_W      = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_KILL  = 2'd1,
		MODE_NEXT  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NONE      = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

endpackage

/* design/rrtt_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module rrtt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/round_robin_task_table.sv */
// Top level of the round-robin task table: slot bits, search logic and entry memory.
//
// A task table of NUM_SLOTS slots with a round-robin pick. Each beat on the input
// channel gives exactly one result beat. In the search stage the slot bits held in
// flip-flops are searched by priority encoders (lowest free slot for add, first used
// slot after the current one for next, wrapping to the lowest used slot), the bits
// are updated and the handle/argument memory is written or read; in the read stage
// the registered read data is placed in the result register. A new item is taken in
// the cycle its predecessor moves into the result register, so only one item at a
// time is in the search and read stages. The slot bits reset at once, so there is
// no clearing pass after reset. result_slot carries the low six bits of the slot
// number.
module round_robin_task_table #(
	parameter int NUM_SLOTS = rrtt_pkg::NUM_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rrtt_pkg::MODE_W-1:0]   mode,
	input  logic [rrtt_pkg::INDEX_W-1:0]  slot_index,
	input  logic [rrtt_pkg::WORD_W-1:0]   task_handle,
	input  logic [rrtt_pkg::WORD_W-1:0]   task_arg,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rrtt_pkg::STATUS_W-1:0] status,
	output logic [rrtt_pkg::INDEX_W-1:0]  result_slot,
	output logic [rrtt_pkg::WORD_W-1:0]   picked_handle,
	output logic [rrtt_pkg::WORD_W-1:0]   picked_arg
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int EW = 2 * rrtt_pkg::WORD_W;

	logic                          in_go;
	logic                          s2_go;

	logic                          vld_s1;
	rrtt_pkg::mode_t               mode_s1;
	logic [rrtt_pkg::INDEX_W-1:0]  idx_s1;
	logic [rrtt_pkg::WORD_W-1:0]   handle_s1;
	logic [rrtt_pkg::WORD_W-1:0]   arg_s1;

	logic                          vld_s2;
	logic                          pick_s2;
	rrtt_pkg::status_t             status_s2;
	logic [rrtt_pkg::INDEX_W-1:0]  slot_s2;

	logic                          out_valid_q;
	rrtt_pkg::status_t             status_q;
	logic [rrtt_pkg::INDEX_W-1:0]  slot_q;
	logic [rrtt_pkg::WORD_W-1:0]   handle_q;
	logic [rrtt_pkg::WORD_W-1:0]   arg_q;

	logic [NUM_SLOTS-1:0]          used_q;
	logic [SW-1:0]                 cur_q;

	logic [NUM_SLOTS-1:0]          used_d;
	logic [SW-1:0]                 cur_d;
	logic                          free_found;
	logic [SW-1:0]                 free_slot;
	logic                          hi_found;
	logic [SW-1:0]                 hi_slot;
	logic                          any_found;
	logic [SW-1:0]                 any_slot;
	logic [SW-1:0]                 kill_slot;
	logic                          kill_bad;
	logic                          ram_we;
	logic                          ram_re;
	logic [SW-1:0]                 ram_addr;
	logic [EW-1:0]                 ram_rdata;
	rrtt_pkg::status_t             status_d;
	logic [rrtt_pkg::INDEX_W-1:0]  slot_d;
	logic                          pick_d;

	assign in_stall = vld_s1 || (vld_s2 && !s2_go);
	assign in_go    = in_valid && !in_stall;
	assign s2_go    = vld_s2 && (!out_valid_q || !out_stall);

	// priority encoders over the slot bits
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		hi_found   = 1'b0;
		hi_slot    = '0;
		any_found  = 1'b0;
		any_slot   = '0;
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_found = 1'b1;
				free_slot  = SW'(k);
			end
			if (used_q[k]) begin
				any_found = 1'b1;
				any_slot  = SW'(k);
			end
			if (used_q[k] && (k > int'(cur_q))) begin
				hi_found = 1'b1;
				hi_slot  = SW'(k);
			end
		end
	end

	assign kill_slot = SW'(idx_s1);
	assign kill_bad  = int'(idx_s1) >= NUM_SLOTS;

	always_comb begin
		used_d   = used_q;
		cur_d    = cur_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = '0;
		status_d = rrtt_pkg::STATUS_OK;
		slot_d   = '0;
		pick_d   = 1'b0;
		unique case (mode_s1)
			rrtt_pkg::MODE_ADD: begin
				if (free_found) begin
					used_d[free_slot] = 1'b1;
					ram_we            = vld_s1;
					ram_addr          = free_slot;
					slot_d            = rrtt_pkg::INDEX_W'(free_slot);
				end else begin
					status_d = rrtt_pkg::STATUS_NONE;
				end
			end
			rrtt_pkg::MODE_KILL: begin
				slot_d = idx_s1;
				if (kill_bad) begin
					status_d = rrtt_pkg::STATUS_BAD_INDEX;
				end else begin
					used_d[kill_slot] = 1'b0;
				end
			end
			rrtt_pkg::MODE_NEXT: begin
				if (any_found) begin
					cur_d    = hi_found ? hi_slot : any_slot;
					ram_re   = vld_s1;
					ram_addr = cur_d;
					slot_d   = rrtt_pkg::INDEX_W'(cur_d);
					pick_d   = 1'b1;
				end else begin
					cur_d    = SW'(NUM_SLOTS - 1);
					status_d = rrtt_pkg::STATUS_NONE;
				end
			end
			rrtt_pkg::MODE_CLEAR: begin
				used_d = '0;
			end
			default: begin
				used_d = used_q;
			end
		endcase
	end

	rrtt_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata ({handle_s1, arg_s1}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			cur_q       <= '0;
		end else begin
			vld_s1 <= in_go;
			if (vld_s1) begin
				vld_s2 <= 1'b1;
				used_q <= used_d;
				cur_q  <= cur_d;
			end else if (s2_go) begin
				vld_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			mode_s1   <= rrtt_pkg::mode_t'(mode);
			idx_s1    <= slot_index;
			handle_s1 <= task_handle;
			arg_s1    <= task_arg;
		end
		if (vld_s1) begin
			pick_s2   <= pick_d;
			status_s2 <= status_d;
			slot_s2   <= slot_d;
		end
		if (s2_go) begin
			status_q <= status_s2;
			slot_q   <= slot_s2;
			handle_q <= pick_s2 ? ram_rdata[EW-1:rrtt_pkg::WORD_W] : '0;
			arg_q    <= pick_s2 ? ram_rdata[rrtt_pkg::WORD_W-1:0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_slot   = slot_q;
	assign picked_handle = handle_q;
	assign picked_arg    = arg_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> !in_go)
		else $error("beat accepted while an item is in the search stage");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> vld_s2)
		else $error("search stage item lost before the read stage");

	a_s2_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !s2_go) |=> vld_s2)
		else $error("read stage item dropped while the result register is full");

	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && mode_s1 == rrtt_pkg::MODE_NEXT && !any_found)
			|=> cur_q == SW'(NUM_SLOTS - 1))
		else $error("current slot not parked at the top after an empty pick");

endmodule
